### rtl/utf8_name_hash_seed_defines.svh
// Assertion macros shared by the RTL files that carry checks.
// Each macro expects clk and rst_n in scope.
`ifndef UTF8_NAME_HASH_SEED_DEFINES_SVH
`define UTF8_NAME_HASH_SEED_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define U8HS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define U8HS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/u8hs_pkg.sv
package u8hs_pkg;

  localparam logic [31:0] FNV_BASIS     = 32'h811c9dc5;
  localparam logic [31:0] FNV_PRIME     = 32'h01000193;
  localparam logic [31:0] MIX_K1        = 32'h7feb352d;
  localparam logic [31:0] MIX_K2        = 32'h846ca68b;
  localparam logic [31:0] SEED_FALLBACK = 32'h6d2b79f5;

  // Queue between decoder and hash engine; depth must be a power of two.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Configuration address: one 32-bit register, word index in paddr[2].
  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-3:0] REG_ROOT_SEED = '0;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BLANK   = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       last_byte;
    logic       no_byte;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] name_hash;
    logic [31:0] stream_seed;
  } out_item_t;

  // One decoded item: up to two UTF-16 units, and optionally the end of name.
  typedef struct packed {
    logic        has_unit;
    logic        pair;
    logic [15:0] unit_a;
    logic [15:0] unit_b;
    logic        is_end;
    status_t     status;
  } q_entry_t;

  // Queue status seen by the two sides.
  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_UNIT2,
    B_END,
    B_MIX2,
    B_FIN
  } back_state_t;

endpackage

### rtl/u8hs_front.sv
module u8hs_front import u8hs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  q_stat_t  q_stat,
  output logic     q_push,
  output q_entry_t q_entry
);

  logic [20:0] partial_r, partial_nxt;
  logic [1:0]  remain_r, remain_nxt;
  logic [1:0]  minc_r, minc_nxt;
  logic        nontrim_r, nontrim_nxt;
  logic        err_r, err_nxt;
  logic        accept;
  q_entry_t    ent;

  function automatic logic is_trim(input logic [20:0] cp);
    logic hit;
    hit = (cp >= 21'h000009 && cp <= 21'h00000d) ||
          (cp >= 21'h002000 && cp <= 21'h00200a) ||
          cp == 21'h000020 || cp == 21'h0000a0 || cp == 21'h001680 ||
          cp == 21'h002028 || cp == 21'h002029 || cp == 21'h00202f ||
          cp == 21'h00205f || cp == 21'h003000 || cp == 21'h00feff;
    return hit;
  endfunction

  assign accept   = in_valid && !q_stat.full;
  assign in_stall = q_stat.full;

  always_comb begin
    logic [7:0]  b;
    logic [20:0] cp;
    logic [20:0] pcat;
    logic [20:0] sdiff;
    logic [20:0] minv;
    logic        fin;
    logic        bad_end;

    b           = in_data.name_byte;
    cp          = '0;
    pcat        = '0;
    sdiff       = '0;
    minv        = '0;
    fin         = 1'b0;
    bad_end     = 1'b0;
    partial_nxt = partial_r;
    remain_nxt  = remain_r;
    minc_nxt    = minc_r;
    nontrim_nxt = nontrim_r;
    err_nxt     = err_r;
    ent         = '0;
    ent.status  = ST_OK;

    if (accept) begin
      if (!in_data.no_byte && !err_r) begin
        if (remain_r == 2'd0) begin
          if (b[7] == 1'b0) begin
            fin = 1'b1;
            cp  = {13'b0, b};
          end else if (b[7:5] == 3'b110) begin
            partial_nxt = {16'b0, b[4:0]};
            remain_nxt  = 2'd1;
            minc_nxt    = 2'd1;
          end else if (b[7:4] == 4'b1110) begin
            partial_nxt = {17'b0, b[3:0]};
            remain_nxt  = 2'd2;
            minc_nxt    = 2'd2;
          end else if (b[7:3] == 5'b11110) begin
            partial_nxt = {18'b0, b[2:0]};
            remain_nxt  = 2'd3;
            minc_nxt    = 2'd3;
          end else begin
            err_nxt = 1'b1;
          end
        end else if (b[7:6] != 2'b10) begin
          err_nxt = 1'b1;
        end else begin
          pcat        = {partial_r[14:0], b[5:0]};
          partial_nxt = pcat;
          remain_nxt  = remain_r - 2'd1;
          if (remain_r == 2'd1) begin
            case (minc_r)
              2'd1:    minv = 21'h000080;
              2'd2:    minv = 21'h000800;
              default: minv = 21'h010000;
            endcase
            // Reject overlong forms, values past the last plane and surrogates.
            if (pcat < minv || pcat > 21'h10ffff ||
                (pcat >= 21'h00d800 && pcat <= 21'h00dfff)) begin
              err_nxt = 1'b1;
            end else begin
              fin = 1'b1;
              cp  = pcat;
            end
            partial_nxt = '0;
            minc_nxt    = 2'd0;
          end
        end
      end

      if (fin) begin
        if (!is_trim(cp)) begin
          nontrim_nxt = 1'b1;
        end
        ent.has_unit = 1'b1;
        if (cp <= 21'h00ffff) begin
          ent.unit_a = cp[15:0];
        end else begin
          // Split into a high and a low surrogate.
          sdiff      = cp - 21'h010000;
          ent.pair   = 1'b1;
          ent.unit_a = {6'b110110, sdiff[19:10]};
          ent.unit_b = {6'b110111, sdiff[9:0]};
        end
      end

      if (in_data.no_byte || in_data.last_byte) begin
        bad_end    = err_nxt || (remain_nxt != 2'd0);
        ent.is_end = 1'b1;
        if (bad_end) begin
          ent.status = ST_INVALID;
        end else if (!nontrim_nxt) begin
          ent.status = ST_BLANK;
        end else begin
          ent.status = ST_OK;
        end
        partial_nxt = '0;
        remain_nxt  = 2'd0;
        minc_nxt    = 2'd0;
        nontrim_nxt = 1'b0;
        err_nxt     = 1'b0;
      end
    end
  end

  assign q_push  = accept && (ent.has_unit || ent.is_end);
  assign q_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      remain_r  <= 2'd0;
      minc_r    <= 2'd0;
      nontrim_r <= 1'b0;
      err_r     <= 1'b0;
    end else begin
      partial_r <= partial_nxt;
      remain_r  <= remain_nxt;
      minc_r    <= minc_nxt;
      nontrim_r <= nontrim_nxt;
      err_r     <= err_nxt;
    end
  end

endmodule

### rtl/u8hs_fifo.sv
`include "utf8_name_hash_seed_defines.svh"

module u8hs_fifo import u8hs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_push,
  input  q_entry_t q_entry,
  input  logic     q_pop,
  output q_entry_t q_head,
  output q_stat_t  q_stat
);

  q_entry_t           q_mem_r [QDEPTH];
  logic [QAW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]     count_r, count_nxt;

  assign q_head          = q_mem_r[rd_ptr_r];
  assign q_stat.full     = (count_r == QCW'(QDEPTH));
  assign q_stat.nonempty = (count_r != '0);

  always_comb begin
    wr_ptr_nxt = q_push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (q_push && !q_pop) begin
      count_nxt = count_r + QCW'(1);
    end else if (q_pop && !q_push) begin
      count_nxt = count_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem_r[wr_ptr_r] <= q_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `U8HS_ASSERT_NOW(a_q_no_overflow, q_push, !q_stat.full, "push into full queue")
  `U8HS_ASSERT_NOW(a_q_no_underflow, q_pop, q_stat.nonempty, "pop from empty queue")

endmodule

### rtl/u8hs_back.sv
`include "utf8_name_hash_seed_defines.svh"

module u8hs_back import u8hs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  q_entry_t    q_head,
  input  q_stat_t     q_stat,
  output logic        q_pop,
  input  logic [31:0] root_seed,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  back_state_t state_r, state_nxt;
  q_entry_t    e_r;
  logic [31:0] hash_r, hash_nxt;
  logic [31:0] mix_r;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic        out_free;
  logic        hash_load;
  logic        mix_load;
  logic        out_load;
  logic [31:0] mul_a;
  logic [31:0] mul_k;
  logic [31:0] prod;
  logic [31:0] seed_x;
  logic [31:0] fin_y;

  assign out_free = !out_valid_r || !out_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (q_stat.nonempty) begin
          if (q_head.has_unit && q_head.pair) begin
            state_nxt = B_UNIT2;
          end else if (q_head.is_end) begin
            state_nxt = B_END;
          end
        end
      end
      B_UNIT2: begin
        state_nxt = e_r.is_end ? B_END : B_IDLE;
      end
      B_END: begin
        if (e_r.status == ST_OK) begin
          state_nxt = B_MIX2;
        end else if (out_free) begin
          state_nxt = B_IDLE;
        end
      end
      B_MIX2: begin
        state_nxt = B_FIN;
      end
      B_FIN: begin
        if (out_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // Datapath control; one shared multiplier serves hashing and mixing.
  always_comb begin
    q_pop     = 1'b0;
    hash_load = 1'b0;
    mix_load  = 1'b0;
    out_load  = 1'b0;
    mul_a     = hash_r;
    mul_k     = FNV_PRIME;
    seed_x    = root_seed ^ hash_r;
    case (state_r)
      B_IDLE: begin
        q_pop     = q_stat.nonempty;
        hash_load = q_stat.nonempty && q_head.has_unit;
        mul_a     = hash_r ^ {16'b0, q_head.unit_a};
      end
      B_UNIT2: begin
        hash_load = 1'b1;
        mul_a     = hash_r ^ {16'b0, e_r.unit_b};
      end
      B_END: begin
        if (e_r.status == ST_OK) begin
          mix_load = 1'b1;
          mul_a    = seed_x ^ (seed_x >> 16);
          mul_k    = MIX_K1;
        end else begin
          out_load = out_free;
        end
      end
      B_MIX2: begin
        mix_load = 1'b1;
        mul_a    = mix_r ^ (mix_r >> 15);
        mul_k    = MIX_K2;
      end
      B_FIN: begin
        out_load = out_free;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  assign prod  = 32'(mul_a * mul_k);
  assign fin_y = mix_r ^ (mix_r >> 16);

  always_comb begin
    hash_nxt      = hash_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (hash_load) begin
      hash_nxt = prod;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      hash_nxt      = FNV_BASIS;
      if (state_r == B_FIN) begin
        out_data_nxt.status      = ST_OK;
        out_data_nxt.name_hash   = hash_r;
        out_data_nxt.stream_seed = (fin_y == '0) ? SEED_FALLBACK : fin_y;
      end else begin
        out_data_nxt.status      = e_r.status;
        out_data_nxt.name_hash   = '0;
        out_data_nxt.stream_seed = SEED_FALLBACK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      e_r <= q_head;
    end
    if (mix_load) begin
      mix_r <= prod;
    end
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      hash_r      <= FNV_BASIS;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hash_r      <= hash_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `U8HS_ASSERT_NOW(a_seed_nonzero, out_valid_r, out_data_r.stream_seed != '0,
    "stream seed is zero")
  `U8HS_ASSERT_NOW(a_fail_fixed, out_valid_r && out_data_r.status != ST_OK,
    out_data_r.name_hash == '0 && out_data_r.stream_seed == SEED_FALLBACK,
    "failed name carries hash or seed")
  `U8HS_ASSERT_NEXT(a_hash_restart, out_load, hash_r == FNV_BASIS,
    "hash not restarted after result")

endmodule

### rtl/utf8_name_hash_seed.sv
// UTF-8 name hash and stream seed.
// Input channel (in_valid/in_stall/in_data): one UTF-8 byte of a name per item;
// last_byte closes the name, and an item with no_byte set closes it with no byte.
// Output channel (out_valid/out_stall/out_data): one item per closed name with
// status (ok, empty/whitespace-only, invalid UTF-8), the FNV-1a 32 hash over the
// UTF-16 units and the stream seed mixed from root_seed xor hash.
// Config port (cfg_*): APB-style, root_seed at byte address 0, pready tied high.
// A decoder takes one byte per cycle, while the queue is not full, into a
// four-entry queue; the hash engine drains it with one multiplier, a unit at a
// time, with a second step (B_UNIT2) when a byte completes a supplementary code
// point. Closing a valid name takes two mix multiplies (B_END, B_MIX2) and the
// final step (B_FIN); any other name is closed in B_END alone.
// in_stall rises only when the queue is full.
// Reset clears the name state, the queue and root_seed; no result is pending.
// While out_stall is high the result holds, the engine waits at its next
// result, and input is still taken until the queue fills.
module utf8_name_hash_seed import u8hs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [31:0] root_seed_r, root_seed_nxt;
  logic        cfg_hit;
  logic        q_push;
  logic        q_pop;
  q_entry_t    q_entry;
  q_entry_t    q_head;
  q_stat_t     q_stat;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[CFG_AW-1:2] == REG_ROOT_SEED);
  assign cfg_prdata = cfg_hit ? root_seed_r : '0;

  always_comb begin
    root_seed_nxt = root_seed_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      root_seed_nxt = cfg_pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_seed_r <= '0;
    end else begin
      root_seed_r <= root_seed_nxt;
    end
  end

  u8hs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  u8hs_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_entry (q_entry),
    .q_pop   (q_pop),
    .q_head  (q_head),
    .q_stat  (q_stat)
  );

  u8hs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .root_seed (root_seed_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
